// ----- hdl/pss_pkg.sv -----
// Shared types and constants for the parity split two-window server.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package pss_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 1024;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W       = PTR_W + 1;
	localparam int ID_W        = 16;

	// Request action codes.
	localparam logic ACT_ARRIVE = 1'b0;
	localparam logic ACT_SERVE  = 1'b1;

	// Window codes.
	localparam logic WIN_A = 1'b0;
	localparam logic WIN_B = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STS_ENQUEUED = 2'd0,
		STS_DROPPED  = 2'd1,
		STS_SERVED   = 2'd2,
		STS_EMPTY    = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    push;         // write the arriving customer into a queue
		logic    push_b;       // queue select for push: 1 = even queue
		logic    pop;          // read the head of a queue and advance it
		logic    pop_b;        // queue select for pop: 1 = even queue
		logic    load;         // load result registers without a served customer
		logic    load_served;  // load result registers with the popped customer
		status_t sts;          // status for a plain load
		logic    win;          // window for a plain load
	} pss_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic odd_empty;
		logic even_empty;
		logic odd_full;
		logic even_full;
		logic want_b;          // current slot is the B slot
	} pss_stat_t;

endpackage

// ----- hdl/pss_datapath.sv -----
// Datapath of the parity split server: two circular queues in memory,
// their head pointers and counts, the serve slot counter and the result registers.
// Depends on pss_pkg.
module pss_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pss_pkg::pss_cmd_t        cmd,
	input  logic [pss_pkg::ID_W-1:0] customer_id,
	output pss_pkg::pss_stat_t       stat,
	output logic [1:0]               status,
	output logic [pss_pkg::ID_W-1:0] served_id,
	output logic                     window,
	output logic                     all_served
);
	import pss_pkg::*;

	logic [ID_W-1:0]  odd_mem  [QUEUE_DEPTH];
	logic [ID_W-1:0]  even_mem [QUEUE_DEPTH];
	logic [ID_W-1:0]  rd_data_q;
	logic [PTR_W-1:0] odd_head_q, even_head_q;
	logic [CNT_W-1:0] odd_cnt_q, even_cnt_q;
	logic [CNT_W-1:0] odd_cnt_d, even_cnt_d;
	logic [1:0]       phase_q;
	logic             sel_b_q;
	logic [PTR_W-1:0] wr_addr;
	logic [SUM_W-1:0] wr_sum;
	logic [PTR_W-1:0] push_head;
	logic [CNT_W-1:0] push_cnt;

	// Status toward the controller.
	assign stat.odd_empty  = (odd_cnt_q == '0);
	assign stat.even_empty = (even_cnt_q == '0);
	assign stat.odd_full   = (odd_cnt_q == CNT_W'(QUEUE_DEPTH));
	assign stat.even_full  = (even_cnt_q == CNT_W'(QUEUE_DEPTH));
	assign stat.want_b     = (phase_q >= 2'd2);

	// Write address is the tail: head plus count, wrapped once.
	assign push_head = cmd.push_b ? even_head_q : odd_head_q;
	assign push_cnt  = cmd.push_b ? even_cnt_q : odd_cnt_q;
	always_comb begin
		wr_sum = SUM_W'(push_head) + SUM_W'(push_cnt);
		if (wr_sum >= SUM_W'(QUEUE_DEPTH)) begin
			wr_sum = wr_sum - SUM_W'(QUEUE_DEPTH);
		end
		wr_addr = PTR_W'(wr_sum);
	end

	// Next counts, used for the counters and the all-served flag.
	always_comb begin
		odd_cnt_d  = odd_cnt_q;
		even_cnt_d = even_cnt_q;
		if (cmd.push && !cmd.push_b) odd_cnt_d = odd_cnt_q + 1'b1;
		if (cmd.push && cmd.push_b)  even_cnt_d = even_cnt_q + 1'b1;
		if (cmd.pop && !cmd.pop_b)   odd_cnt_d = odd_cnt_q - 1'b1;
		if (cmd.pop && cmd.pop_b)    even_cnt_d = even_cnt_q - 1'b1;
	end

	// Queue storage: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.push && !cmd.push_b) odd_mem[wr_addr] <= customer_id;
		if (cmd.push && cmd.push_b)  even_mem[wr_addr] <= customer_id;
		if (cmd.pop) begin
			rd_data_q <= cmd.pop_b ? even_mem[even_head_q] : odd_mem[odd_head_q];
		end
	end

	// Pointers, counts and the serve slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_head_q  <= '0;
			even_head_q <= '0;
			odd_cnt_q   <= '0;
			even_cnt_q  <= '0;
			phase_q     <= '0;
			sel_b_q     <= WIN_A;
		end else begin
			odd_cnt_q  <= odd_cnt_d;
			even_cnt_q <= even_cnt_d;
			if (cmd.pop) begin
				sel_b_q <= cmd.pop_b;
				phase_q <= (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
				if (cmd.pop_b) begin
					even_head_q <= (even_head_q == PTR_W'(QUEUE_DEPTH - 1)) ?
						'0 : even_head_q + 1'b1;
				end else begin
					odd_head_q <= (odd_head_q == PTR_W'(QUEUE_DEPTH - 1)) ?
						'0 : odd_head_q + 1'b1;
				end
			end
		end
	end

	// Result registers, loaded once per transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status     <= cmd.sts;
			served_id  <= '0;
			window     <= cmd.win;
			all_served <= (odd_cnt_d == '0) && (even_cnt_d == '0);
		end else if (cmd.load_served) begin
			status     <= STS_SERVED;
			served_id  <= rd_data_q;
			window     <= sel_b_q;
			all_served <= (odd_cnt_d == '0) && (even_cnt_d == '0);
		end
	end

endmodule

// ----- hdl/pss_ctrl.sv -----
// Controller of the parity split server: handshakes and the decision of
// what each request does to the queues.
// Depends on pss_pkg.
module pss_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic                  action,
	input  logic                  id_lsb,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  pss_pkg::pss_stat_t    stat,
	output pss_pkg::pss_cmd_t     cmd
);
	import pss_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;
	logic   accept;
	logic   arr_b;
	logic   arr_full;
	logic   use_b;

	// Take a request when idle and the result register is free or draining.
	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid || rsp_ready);
	assign accept    = req_valid && req_ready;

	// Odd numbers go to window A, even numbers to window B.
	assign arr_b    = ~id_lsb;
	assign arr_full = arr_b ? stat.even_full : stat.odd_full;

	// Serve the slot's queue, or the other one when it is empty.
	assign use_b = stat.want_b ? !stat.even_empty : stat.odd_empty;

	// Commands for the datapath.
	always_comb begin
		cmd             = '0;
		cmd.sts         = STS_ENQUEUED;
		cmd.load_served = (state_q == ST_READ);
		if (accept) begin
			if (action == ACT_ARRIVE) begin
				cmd.load   = 1'b1;
				cmd.win    = arr_b;
				cmd.push   = !arr_full;
				cmd.push_b = arr_b;
				cmd.sts    = arr_full ? STS_DROPPED : STS_ENQUEUED;
			end else if (stat.odd_empty && stat.even_empty) begin
				cmd.load = 1'b1;
				cmd.win  = stat.want_b;
				cmd.sts  = STS_EMPTY;
			end else begin
				cmd.pop   = 1'b1;
				cmd.pop_b = use_b;
			end
		end
	end

	// State and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rsp_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.pop) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.load || cmd.load_served) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/parity_split_two_to_one_server.sv -----
// Results: an arrival, or a serve with nobody waiting, shows its result in the cycle after acceptance;
// a serve that pops a customer reads it into a registered read port, then loads the result registers.
// Throughput: one arrival per cycle while the result register is free or draining; a popping
// serve holds off the next request until the queue memory's registered read port delivers.
// Reset: arst_n clears pointers, counts, the serve slot and the handshake state; queue storage
// is not cleared, since every read is guarded by the counts.
module parity_split_two_to_one_server (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic                     action,
	input  logic [pss_pkg::ID_W-1:0] customer_id,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic [1:0]               status,
	output logic [pss_pkg::ID_W-1:0] served_id,
	output logic                     window,
	output logic                     all_served
);
	import pss_pkg::*;

	pss_cmd_t  cmd;
	pss_stat_t stat;

	// Handshakes and queue decisions.
	pss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (action),
		.id_lsb    (customer_id[0]),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Queues and result registers.
	pss_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.customer_id (customer_id),
		.stat        (stat),
		.status      (status),
		.served_id   (served_id),
		.window      (window),
		.all_served  (all_served)
	);

endmodule

// ----- hdl/pss_checker.sv -----
// Port-level checks for the parity split server, bound to the top level.
// Depends on pss_pkg and parity_split_two_to_one_server.
module pss_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic                     action,
	input logic [pss_pkg::ID_W-1:0] customer_id,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [1:0]               status,
	input logic [pss_pkg::ID_W-1:0] served_id,
	input logic                     window,
	input logic                     all_served
);
	import pss_pkg::*;

	// A stalled result holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(served_id)
			&& $stable(window) && $stable(all_served))
		else $error("result changed while stalled");

	// Only a served transaction carries a customer number.
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != STS_SERVED) |-> served_id == '0)
		else $error("served_id nonzero without a served customer");

	// Nobody waiting means both queues are empty.
	a_empty_all: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STS_EMPTY) |-> all_served)
		else $error("empty report without all_served");

	// A dropped arrival means its queue is full, so not all are served.
	a_drop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STS_DROPPED) |-> !all_served)
		else $error("drop reported with empty queues");

endmodule

bind parity_split_two_to_one_server pss_checker u_pss_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the parity split two-window server.
// Depends on pss_pkg and parity_split_two_to_one_server; a scoreboard class predicts every result.
module tb;
	import pss_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 400;

	// One expected or observed response transaction.
	typedef struct {
		status_t           status;
		logic [ID_W-1:0]   served_id;
		logic              window;
		logic              all_served;
	} service_result_t;

	// Scoreboard: shadow queues, serve slot and the line of pending results.
	class service_scoreboard;
		logic [ID_W-1:0] odd_line[$];
		logic [ID_W-1:0] even_line[$];
		logic [1:0]      slot;
		service_result_t pending[$];
		int unsigned     errors;

		function new();
			slot = 2'd0;
			errors = 0;
		endfunction

		// Advance the shadow state for one accepted request transaction.
		function void note_request(logic act, logic [ID_W-1:0] id);
			service_result_t r;
			logic want_b;
			logic use_b;
			r.served_id = '0;
			if (act == ACT_ARRIVE) begin
				if (id[0]) begin
					r.window = WIN_A;
					if (odd_line.size() >= QUEUE_DEPTH) begin
						r.status = STS_DROPPED;
					end else begin
						odd_line.push_back(id);
						r.status = STS_ENQUEUED;
					end
				end else begin
					r.window = WIN_B;
					if (even_line.size() >= QUEUE_DEPTH) begin
						r.status = STS_DROPPED;
					end else begin
						even_line.push_back(id);
						r.status = STS_ENQUEUED;
					end
				end
			end else begin
				want_b = (slot >= 2'd2);
				if (odd_line.size() == 0 && even_line.size() == 0) begin
					r.status = STS_EMPTY;
					r.window = want_b;
				end else begin
					// Fall back to the other window when the slot's queue is empty.
					use_b = want_b;
					if (use_b && even_line.size() == 0)
						use_b = 1'b0;
					else if (!use_b && odd_line.size() == 0)
						use_b = 1'b1;
					if (use_b)
						r.served_id = even_line.pop_front();
					else
						r.served_id = odd_line.pop_front();
					r.status = STS_SERVED;
					r.window = use_b;
					slot = (slot >= 2'd2) ? 2'd0 : slot + 2'd1;
				end
			end
			r.all_served = (odd_line.size() == 0 && even_line.size() == 0);
			pending.push_back(r);
		endfunction

		// Compare one response transaction with the oldest pending result.
		function void check_result(service_result_t got);
			service_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$error("response with no pending result: status %0d served_id %0d",
					got.status, got.served_id);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				errors++;
				$error("status expected %0d actual %0d", want.status, got.status);
			end
			if (got.served_id !== want.served_id) begin
				errors++;
				$error("served_id expected %0d actual %0d", want.served_id, got.served_id);
			end
			if (got.window !== want.window) begin
				errors++;
				$error("window expected %0d actual %0d", want.window, got.window);
			end
			if (got.all_served !== want.all_served) begin
				errors++;
				$error("all_served expected %0d actual %0d", want.all_served, got.all_served);
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            req_valid;
	logic            req_ready;
	logic            action;
	logic [ID_W-1:0] customer_id;
	logic            rsp_valid;
	logic            rsp_ready;
	logic [1:0]      status;
	logic [ID_W-1:0] served_id;
	logic            window;
	logic            all_served;

	service_scoreboard sb = new();
	bit                hold_rsp = 1'b0;
	int unsigned       cycles = 0;

	parity_split_two_to_one_server dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.action      (action),
		.customer_id (customer_id),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.served_id   (served_id),
		.window      (window),
		.all_served  (all_served)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle lengths: mostly none or short, now and then long.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Offer one request transaction and wait for its acceptance.
	task automatic send_request(input logic act, input logic [ID_W-1:0] id);
		req_valid <= 1'b1;
		action <= act;
		customer_id <= id;
		do @(posedge clk); while (!req_ready);
	endtask

	// Let the request side idle for a random stretch, with noise on the payload.
	task automatic pause_sender();
		int unsigned n;
		n = gap_len();
		if (n > 0) begin
			req_valid <= 1'b0;
			action <= 1'($urandom_range(0, 1));
			customer_id <= ID_W'($urandom_range(0, 65535));
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic arrive(input logic [ID_W-1:0] id);
		send_request(ACT_ARRIVE, id);
		pause_sender();
	endtask

	// The customer number is ignored on a serve, so it carries random bits.
	task automatic serve();
		send_request(ACT_SERVE, ID_W'($urandom_range(0, 65535)));
		pause_sender();
	endtask

	// Random traffic with a given percentage of arrivals.
	task automatic random_traffic(input int unsigned count, input int unsigned arrive_pct);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < arrive_pct)
				arrive(ID_W'($urandom_range(0, 65535)));
			else
				serve();
		end
	endtask

	// Response side: random stalls, and one long hold-off on request.
	initial begin
		int unsigned on_len;
		int unsigned off_len;
		bit          hold_taken;
		hold_taken = 1'b0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rsp && !hold_taken) begin
				hold_taken = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				on_len = $urandom_range(1, 40);
				rsp_ready <= 1'b1;
				repeat (on_len) @(posedge clk);
				off_len = gap_len();
				if (off_len > 0) begin
					rsp_ready <= 1'b0;
					repeat (off_len) @(posedge clk);
				end
			end
		end
	end

	// Monitor: check responses first, then note requests accepted at the same edge.
	always @(posedge clk) begin
		service_result_t got;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				got.status = status_t'(status);
				got.served_id = served_id;
				got.window = window;
				got.all_served = all_served;
				sb.check_result(got);
			end
			if (req_valid && req_ready)
				sb.note_request(action, customer_id);
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Main stimulus sequence.
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		action = ACT_ARRIVE;
		customer_id = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: empty serve, extreme ids, slot order and fallback in both directions.
		serve();
		arrive(16'hFFFF);
		arrive(16'h0000);
		arrive(16'h0001);
		arrive(16'hFFFE);
		serve();
		serve();
		serve();
		serve();
		serve();
		arrive(16'h5555);
		arrive(16'h0003);
		serve();
		serve();
		serve();
		arrive(16'hAAAA);
		arrive(16'h0002);
		serve();
		serve();
		serve();

		// Long response hold-off while requests keep coming, so the block backs up.
		hold_rsp = 1'b1;
		for (int i = 0; i < 40; i++)
			send_request(ACT_ARRIVE, ID_W'($urandom_range(0, 65535)));

		// Random traffic: growing, balanced and draining phases.
		random_traffic(130, 70);
		random_traffic(130, 50);
		random_traffic(130, 30);

		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/pss_pkg.sv
hdl/pss_datapath.sv
hdl/pss_ctrl.sv
hdl/parity_split_two_to_one_server.sv
hdl/pss_checker.sv
sim/tb.sv
